/* design/sem_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package sem_pkg;

    localparam int MaxWidth   = 1024;
    localparam int ColW       = $clog2(MaxWidth);
    localparam int RowW       = 16;
    localparam int WidthW     = 11;
    localparam int PixW       = 24;
    localparam int ChanW      = 8;
    localparam int NumChan    = 3;
    localparam int GradW      = 11;
    localparam int SqW        = 20;
    localparam int SumW       = 21;
    localparam int RootW      = 8;
    localparam int RemW       = 10;
    localparam int QueueDepth = 4;
    localparam int QueueAw    = $clog2(QueueDepth);

    localparam logic CfgWidth  = 1'b0;
    localparam logic CfgHeight = 1'b1;

    localparam logic [WidthW-1:0] WidthReset  = 11'd640;
    localparam logic [RowW-1:0]   HeightReset = 16'd480;

    typedef logic signed [GradW-1:0] t_grad;

    typedef struct packed {
        logic                 last;
        t_grad [NumChan-1:0]  gx;
        t_grad [NumChan-1:0]  gy;
    } t_grad_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic t_grad ext(input logic [ChanW-1:0] p);
        ext = t_grad'({3'b000, p});
    endfunction

    // gx = p0 - p2 + 2*p3 - 2*p5 + p6 - p8
    function automatic t_grad grad_x(input logic [ChanW-1:0] p0, input logic [ChanW-1:0] p2,
                                     input logic [ChanW-1:0] p3, input logic [ChanW-1:0] p5,
                                     input logic [ChanW-1:0] p6, input logic [ChanW-1:0] p8);
        grad_x = ext(p0) - ext(p2) + (ext(p3) <<< 1) - (ext(p5) <<< 1) + ext(p6) - ext(p8);
    endfunction

    // gy = p0 + 2*p1 + p2 - p6 - 2*p7 - p8
    function automatic t_grad grad_y(input logic [ChanW-1:0] p0, input logic [ChanW-1:0] p1,
                                     input logic [ChanW-1:0] p2, input logic [ChanW-1:0] p6,
                                     input logic [ChanW-1:0] p7, input logic [ChanW-1:0] p8);
        grad_y = ext(p0) + (ext(p1) <<< 1) + ext(p2) - ext(p6) - (ext(p7) <<< 1) - ext(p8);
    endfunction

endpackage
`default_nettype wire

/* design/sem_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
module sem_fifo (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire sem_pkg::t_grad_entry  i_push_data,
    input  wire logic                  i_pop,
    output sem_pkg::t_grad_entry       o_pop_data,
    output sem_pkg::t_q_status         o_status
);

    sem_pkg::t_grad_entry r_mem [sem_pkg::QueueDepth];
    logic [sem_pkg::QueueAw-1:0] r_wr_ptr;
    logic [sem_pkg::QueueAw-1:0] r_rd_ptr;
    logic [sem_pkg::QueueAw:0]   r_count;
    logic                        do_push;
    logic                        do_pop;

    assign o_status.full  = (r_count == (sem_pkg::QueueAw+1)'(sem_pkg::QueueDepth));
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_pop_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (do_push && !do_pop)      r_count <= r_count + 1'b1;
            else if (!do_push && do_pop) r_count <= r_count - 1'b1;
        end
    end

endmodule
`default_nettype wire

/* design/sem_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module sem_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [sem_pkg::ColW-1:0]      i_width_m1,
    input  wire logic [sem_pkg::RowW-1:0]      i_height_m1,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [sem_pkg::PixW-1:0]      s_axis_tdata,   // red, green, blue
    input  wire logic                          s_axis_tuser,   // frame_start
    input  wire sem_pkg::t_q_status            i_q_status,
    output logic                               o_push,
    output sem_pkg::t_grad_entry               o_push_data
);

    typedef enum logic {S_IDLE, S_UPDATE} t_state;

    t_state r_state;
    logic [sem_pkg::ColW-1:0]   r_col;
    logic [sem_pkg::RowW-1:0]   r_row;
    logic [sem_pkg::ColW-1:0]   r_addr;
    logic [sem_pkg::PixW-1:0]   r_px;
    logic                       r_has;
    logic                       r_last;
    logic [2*sem_pkg::PixW-1:0] r_rd_data;
    logic [2*sem_pkg::PixW-1:0] r_mem [sem_pkg::MaxWidth];
    logic [sem_pkg::PixW-1:0]   r_win [3][3];
    logic [sem_pkg::PixW-1:0]   n_win [3][3];

    logic                     accept;
    logic                     advance;
    logic [sem_pkg::ColW-1:0] c;
    logic [sem_pkg::RowW-1:0] r;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept  = s_axis_tvalid && s_axis_tready;
    assign advance = (r_state == S_UPDATE) && (!r_has || !i_q_status.full);
    assign c = s_axis_tuser ? '0 : r_col;
    assign r = s_axis_tuser ? '0 : r_row;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_win[k][0] = r_win[k][1];
            n_win[k][1] = r_win[k][2];
        end
        n_win[0][2] = r_rd_data[2*sem_pkg::PixW-1:sem_pkg::PixW];
        n_win[1][2] = r_rd_data[sem_pkg::PixW-1:0];
        n_win[2][2] = r_px;
    end

    always_comb begin
        o_push = advance && r_has;
        o_push_data.last = r_last;
        for (int ch = 0; ch < sem_pkg::NumChan; ch++) begin
            o_push_data.gx[ch] = sem_pkg::grad_x(n_win[0][0][ch*8 +: 8], n_win[0][2][ch*8 +: 8],
                                                 n_win[1][0][ch*8 +: 8], n_win[1][2][ch*8 +: 8],
                                                 n_win[2][0][ch*8 +: 8], n_win[2][2][ch*8 +: 8]);
            o_push_data.gy[ch] = sem_pkg::grad_y(n_win[0][0][ch*8 +: 8], n_win[0][1][ch*8 +: 8],
                                                 n_win[0][2][ch*8 +: 8], n_win[2][0][ch*8 +: 8],
                                                 n_win[2][1][ch*8 +: 8], n_win[2][2][ch*8 +: 8]);
        end
    end

    // line store: low half one row up, high half two rows up
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_data <= r_mem[c];
        end
        if (advance) begin
            r_mem[r_addr] <= {r_rd_data[sem_pkg::PixW-1:0], r_px};
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px   <= s_axis_tdata;
            r_addr <= c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_has   <= 1'b0;
            r_last  <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[k][j] <= '0;
                end
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_has  <= (r >= 16'd2) && (c >= 10'd2);
                        r_last <= (r >= 16'd2) && (c >= 10'd2) &&
                                  (r >= i_height_m1) && (c >= i_width_m1);
                        if (c >= i_width_m1) begin
                            r_col <= '0;
                            r_row <= (r >= i_height_m1) ? '0 : r + 1'b1;
                        end else begin
                            r_col <= c + 1'b1;
                            r_row <= r;
                        end
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    if (advance) begin
                        r_win   <= n_win;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

/* design/sem_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module sem_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire sem_pkg::t_q_status             i_q_status,
    input  wire sem_pkg::t_grad_entry           i_pop_data,
    output logic                                o_pop,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [sem_pkg::NumChan*8-1:0]       m_axis_tdata,   // edge_red, edge_green, edge_blue
    output logic                                m_axis_tlast    // frame_last
);

    typedef enum logic [1:0] {B_IDLE, B_SUM, B_ROOT, B_HOLD} t_state;

    t_state r_state;
    logic [2:0]                  r_cnt;
    logic                        r_last_w;
    logic [sem_pkg::SqW-1:0]     r_sqx  [sem_pkg::NumChan];
    logic [sem_pkg::SqW-1:0]     r_sqy  [sem_pkg::NumChan];
    logic                        r_sat  [sem_pkg::NumChan];
    logic [15:0]                 r_v    [sem_pkg::NumChan];
    logic [sem_pkg::RemW-1:0]    r_rem  [sem_pkg::NumChan];
    logic [sem_pkg::RootW-1:0]   r_root [sem_pkg::NumChan];
    logic                        r_out_valid;
    logic [sem_pkg::NumChan*8-1:0] r_out_data;
    logic                        r_out_last;

    logic signed [2*sem_pkg::GradW-1:0] prod_x [sem_pkg::NumChan];
    logic signed [2*sem_pkg::GradW-1:0] prod_y [sem_pkg::NumChan];
    logic [sem_pkg::SumW-1:0]           sum    [sem_pkg::NumChan];
    logic [sem_pkg::RemW+1:0]           rem_s  [sem_pkg::NumChan];
    logic [sem_pkg::RemW+1:0]           trial  [sem_pkg::NumChan];
    logic                               load;

    assign o_pop = (r_state == B_IDLE) && !i_q_status.empty;
    assign load  = (r_state == B_HOLD) && (!r_out_valid || m_axis_tready);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    always_comb begin
        for (int i = 0; i < sem_pkg::NumChan; i++) begin
            prod_x[i] = $signed(i_pop_data.gx[i]) * $signed(i_pop_data.gx[i]);
            prod_y[i] = $signed(i_pop_data.gy[i]) * $signed(i_pop_data.gy[i]);
            sum[i]    = {1'b0, r_sqx[i]} + {1'b0, r_sqy[i]};
            rem_s[i]  = {r_rem[i], r_v[i][15:14]};
            trial[i]  = {2'b00, r_root[i], 2'b01};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (o_pop) r_state <= B_SUM;
                end
                B_SUM: begin
                    r_cnt   <= '0;
                    r_state <= B_ROOT;
                end
                B_ROOT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 3'd7) r_state <= B_HOLD;
                end
                B_HOLD: begin
                    if (load) r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_last_w <= i_pop_data.last;
        end
        for (int i = 0; i < sem_pkg::NumChan; i++) begin
            if (o_pop) begin
                r_sqx[i] <= prod_x[i][sem_pkg::SqW-1:0];
                r_sqy[i] <= prod_y[i][sem_pkg::SqW-1:0];
            end
            if (r_state == B_SUM) begin
                r_sat[i]  <= (sum[i][sem_pkg::SumW-1:16] != '0);
                r_v[i]    <= sum[i][15:0];
                r_rem[i]  <= '0;
                r_root[i] <= '0;
            end
            if (r_state == B_ROOT) begin
                r_v[i] <= {r_v[i][13:0], 2'b00};
                if (rem_s[i] >= trial[i]) begin
                    r_rem[i]  <= sem_pkg::RemW'(rem_s[i] - trial[i]);
                    r_root[i] <= {r_root[i][sem_pkg::RootW-2:0], 1'b1};
                end else begin
                    r_rem[i]  <= rem_s[i][sem_pkg::RemW-1:0];
                    r_root[i] <= {r_root[i][sem_pkg::RootW-2:0], 1'b0};
                end
            end
            if (load) begin
                r_out_data[i*8 +: 8] <= r_sat[i] ? 8'hFF : r_root[i];
            end
        end
        if (load) begin
            r_out_last <= r_last_w;
        end
    end

endmodule
`default_nettype wire

/* design/sobel_edge_magnitude_rgb.sv */
`timescale 1ns / 1ps
`default_nettype none
// sobel edge magnitude on rgb pixels, 3x3 window, one channel operator each
// input stream: s_axis tdata carries red, green, blue; tuser flags the first
// pixel of a frame. output stream: m_axis tdata carries the clamped magnitude
// per channel, tlast marks the last interior result of the frame.
// only interior pixels give a result, (height-2)x(width-2) per frame.
// configuration: i_cfg_we writes register i_cfg_idx (0 width, 1 height); the
// user must write only while the block is idle; the block does not enforce it.
// pacing: the front takes a new pixel only after the window and line store
// update of the last one, which follows the registered line store read, and
// holds off while the queue is full. the back end works on one result at a
// time (square, sum, 8 root steps, load), so a run of interior pixels is
// paced by it; a 4-entry queue between front and back lets the front run ahead.
// reset clears position, window, queue and output; width 640, height 480;
// line store contents are undefined until written.
// when the receiver stalls, the result holds, the queue fills and then
// s_axis_tready drops.
module sobel_edge_magnitude_rgb (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
    input  wire logic        s_axis_tuser,   // frame_start
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // edge_red, edge_green, edge_blue
    output logic             m_axis_tlast    // frame_last
);

    logic [sem_pkg::WidthW-1:0] r_width;
    logic [sem_pkg::RowW-1:0]   r_height;
    logic [sem_pkg::ColW-1:0]   width_m1;
    logic [sem_pkg::RowW-1:0]   height_m1;

    sem_pkg::t_q_status   q_status;
    sem_pkg::t_grad_entry push_data;
    sem_pkg::t_grad_entry pop_data;
    logic                 push;
    logic                 pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= sem_pkg::WidthReset;
            r_height <= sem_pkg::HeightReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sem_pkg::CfgWidth:  r_width  <= i_cfg_data[sem_pkg::WidthW-1:0];
                sem_pkg::CfgHeight: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_width < 11'd3) begin
            width_m1 = 10'd2;
        end else if (r_width > 11'(sem_pkg::MaxWidth)) begin
            width_m1 = sem_pkg::ColW'(sem_pkg::MaxWidth - 1);
        end else begin
            width_m1 = sem_pkg::ColW'(r_width - 1'b1);
        end
        height_m1 = (r_height < 16'd3) ? 16'd2 : r_height - 1'b1;
    end

    sem_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_width_m1    (width_m1),
        .i_height_m1   (height_m1),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_status    (q_status),
        .o_push        (push),
        .o_push_data   (push_data)
    );

    sem_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_status    (q_status)
    );

    sem_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_status    (q_status),
        .i_pop_data    (pop_data),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
`default_nettype wire

/* dv/sobel_checker.sv */
`timescale 1ns / 1ps
module sobel_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_px_valid,
    input  logic        i_px_ready,
    input  logic [23:0] i_px_data,
    input  logic        i_px_first,
    input  logic        i_edge_valid,
    input  logic        i_edge_ready,
    input  logic [23:0] i_edge_data,
    input  logic        i_edge_last,
    output int          o_pending,
    output int          o_errors
);

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_edge;

    logic [47:0]                row_mem [sem_pkg::MaxWidth];
    logic [23:0]                win [3][3];
    int unsigned                col_pos;
    int unsigned                row_pos;
    logic [sem_pkg::WidthW-1:0] width_reg;
    logic [sem_pkg::RowW-1:0]   height_reg;
    t_edge                      edge_q[$];
    int                         errors;

    assign o_pending = edge_q.size();
    assign o_errors  = errors;

    function automatic logic [7:0] root_clamped(input int unsigned v);
        int unsigned root;
        int unsigned b;
        root = 0;
        b = 32'h4000_0000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= root + b) begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b >>= 2;
        end
        return (root > 255) ? 8'd255 : root[7:0];
    endfunction

    function automatic logic [7:0] channel_edge(input int sh);
        int p[9];
        int gx;
        int gy;
        for (int k = 0; k < 9; k++) p[k] = int'((win[k / 3][k % 3] >> sh) & 24'hff);
        gx = p[0] - p[2] + 2 * p[3] - 2 * p[5] + p[6] - p[8];
        gy = p[0] + 2 * p[1] + p[2] - p[6] - 2 * p[7] - p[8];
        return root_clamped(gx * gx + gy * gy);
    endfunction

    task automatic predict_pixel(input logic [23:0] px, input logic first);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        logic [47:0] ent;
        t_edge e;
        w = width_reg;
        h = height_reg;
        if (w < 3) w = 3;
        if (w > sem_pkg::MaxWidth) w = sem_pkg::MaxWidth;
        if (h < 3) h = 3;
        if (first) begin
            col_pos = 0;
            row_pos = 0;
        end
        c = (col_pos >= sem_pkg::MaxWidth) ? sem_pkg::MaxWidth - 1 : col_pos;
        r = row_pos;
        ent = row_mem[c];
        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = ent[47:24];
        win[1][2] = ent[23:0];
        win[2][2] = px;
        row_mem[c] = {ent[23:0], px};
        if (r >= 2 && c >= 2) begin
            e.red   = channel_edge(0);
            e.green = channel_edge(8);
            e.blue  = channel_edge(16);
            e.last  = (r >= h - 1 && c >= w - 1);
            edge_q.insert(edge_q.size(), e);
        end
        if (c >= w - 1) begin
            col_pos = 0;
            row_pos = (r >= h - 1) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    task automatic check_edge();
        t_edge e;
        if (edge_q.size() == 0) begin
            $display("%0t: unexpected result %h last %b", $time, i_edge_data, i_edge_last);
            errors++;
            return;
        end
        e = edge_q.pop_front();
        if (i_edge_data[7:0] !== e.red) begin
            $display("%0t: red expected %0d actual %0d", $time, e.red, i_edge_data[7:0]);
            errors++;
        end
        if (i_edge_data[15:8] !== e.green) begin
            $display("%0t: green expected %0d actual %0d", $time, e.green, i_edge_data[15:8]);
            errors++;
        end
        if (i_edge_data[23:16] !== e.blue) begin
            $display("%0t: blue expected %0d actual %0d", $time, e.blue, i_edge_data[23:16]);
            errors++;
        end
        if (i_edge_last !== e.last) begin
            $display("%0t: last expected %b actual %b", $time, e.last, i_edge_last);
            errors++;
        end
    endtask

    initial errors = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) win[k / 3][k % 3] = '0;
            col_pos = 0;
            row_pos = 0;
            width_reg = sem_pkg::WidthReset;
            height_reg = sem_pkg::HeightReset;
            edge_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == sem_pkg::CfgWidth) width_reg = i_cfg_data[sem_pkg::WidthW-1:0];
                else height_reg = i_cfg_data;
            end
            if (i_edge_valid && i_edge_ready) check_edge();
            if (i_px_valid && i_px_ready) predict_pixel(i_px_data, i_px_first);
        end
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
module testbench;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    int          pending;
    int          errors;
    int          pixel_count;
    bit          no_gaps;
    bit          hold_req;

    sobel_edge_magnitude_rgb u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    sobel_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_px_valid   (s_axis_tvalid),
        .i_px_ready   (s_axis_tready),
        .i_px_data    (s_axis_tdata),
        .i_px_first   (s_axis_tuser),
        .i_edge_valid (m_axis_tvalid),
        .i_edge_ready (m_axis_tready),
        .i_edge_data  (m_axis_tdata),
        .i_edge_last  (m_axis_tlast),
        .o_pending    (pending),
        .o_errors     (errors)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int n;
        m_axis_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            n = no_gaps ? 0 : $urandom_range(0, 7);
            if (hold_req) begin
                hold_req = 1'b0;
                n = 400;
            end
            if (n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    task automatic write_reg(input logic idx, input logic [15:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic send_pixel(input logic [23:0] px, input logic first);
        int n;
        n = no_gaps ? 0 : $urandom_range(0, 7);
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        s_axis_tuser  <= first;
        do @(posedge i_clk); while (!s_axis_tready);
        pixel_count++;
    endtask

    function automatic logic [23:0] pick_pixel(input int pattern, input int r, input int c,
                                               input int w);
        logic [23:0] px;
        case (pattern)
            0: px = 24'($urandom);
            1: for (int k = 0; k < 24; k += 8) px[k +: 8] = $urandom_range(0, 1) ? 8'hff : 8'h00;
            2: px = (2 * c >= w) ? 24'hffffff : 24'h000000;
            3: px = (r == 0) ? 24'hffffff : 24'h000000;
            4: px = 24'hffffff;
            default: px = 24'h000000;
        endcase
        return px;
    endfunction

    // one frame; stop_at below w*h cuts it short, noise_first throws stray frame flags
    task automatic send_frame(input int w, input int h, input bit first, input int pattern,
                              input int stop_at, input bit noise_first);
        int k;
        k = 0;
        for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
                if (k == stop_at) return;
                send_pixel(pick_pixel(pattern, r, c, w),
                           (k == 0) ? first : (noise_first && $urandom_range(0, 99) == 0));
                k++;
            end
        end
    endtask

    task automatic configure(input logic [10:0] w_raw, input logic [15:0] h_raw);
        wait_idle();
        write_reg(sem_pkg::CfgWidth, {5'($urandom), w_raw});
        write_reg(sem_pkg::CfgHeight, h_raw);
        i_cfg_we <= 1'b0;
    endtask

    function automatic int eff_width(input logic [10:0] w_raw);
        return (w_raw < 3) ? 3 : (w_raw > sem_pkg::MaxWidth) ? sem_pkg::MaxWidth : int'(w_raw);
    endfunction

    initial begin
        logic [10:0] w_raw;
        logic [15:0] h_raw;
        int          w;
        int          h;
        int          phase;
        int          frames;
        int          stop_at;
        bit          whole;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = sem_pkg::CfgWidth;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        no_gaps       = 1'b0;
        hold_req      = 1'b0;
        pixel_count   = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: smallest frame, flat, saturating horizontal and vertical edges
        configure(11'd3, 16'd3);
        send_frame(3, 3, 1'b1, 5, 9, 1'b0);
        send_frame(3, 3, 1'b1, 2, 9, 1'b0);
        send_frame(3, 3, 1'b0, 3, 9, 1'b0);
        send_frame(3, 3, 1'b1, 4, 9, 1'b0);

        // widest line, part of the first row only
        configure(11'd1024, 16'd3);
        send_frame(1024, 3, 1'b1, 0, 400, 1'b0);

        phase = 0;
        while (pixel_count < 1650) begin
            w_raw = 11'($urandom_range(3, 12));
            h_raw = 16'($urandom_range(3, 8));
            case (phase % 10)
                1: w_raw = 11'($urandom_range(0, 2));
                3: h_raw = 16'($urandom_range(0, 2));
                4: begin
                    w_raw = 11'd12;
                    h_raw = 16'd8;
                end
                5: w_raw = 11'($urandom_range(1025, 2047));
                7: h_raw = 16'hffff;
                default: ;
            endcase
            w = eff_width(w_raw);
            h = (h_raw < 3) ? 3 : int'(h_raw);
            configure(w_raw, h_raw);
            no_gaps = (phase % 4 == 2);
            if (phase == 4) hold_req = 1'b1;
            frames = (w > 12) ? 1 : $urandom_range(1, 3);
            whole = 1'b1;
            for (int f = 0; f < frames; f++) begin
                stop_at = w * ((h > 8) ? 4 : h);
                if (w > 12) stop_at = $urandom_range(1, 200);
                else if (h > 8 || $urandom_range(0, 9) == 0)
                    stop_at = $urandom_range(1, stop_at);
                send_frame(w, h, !whole || f == 0 || $urandom_range(0, 1),
                           ($urandom_range(0, 2) == 0) ? 1 : 0, stop_at,
                           $urandom_range(0, 3) == 0);
                whole = (stop_at == w * h);
                if (!whole) break;
            end
            phase++;
        end
        s_axis_tvalid <= 1'b0;
        no_gaps = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* sobel_edge_magnitude_rgb.f */
design/sem_pkg.sv
design/sem_fifo.sv
design/sem_front.sv
design/sem_back.sv
design/sobel_edge_magnitude_rgb.sv
dv/sobel_checker.sv
dv/testbench.sv
